FILE: src/emadb_pkg.sv
// Shared types, constants and codes of the multichannel EMA deadband normaliser.
// No dependencies; every other file of the block but emadb_ram imports this package.
`default_nettype none

package emadb_pkg;

  // Block dimensions
  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int WEIGHT_BITS = 8;

  // Fixed field widths of the channels
  localparam int CMD_W      = 2;
  localparam int CHAN_W     = 3;
  localparam int VAL_W      = 12;
  localparam int SMOOTH_W   = 12;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int WREG_W     = 9;
  localparam int DB_W       = 12;

  // Derived widths
  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AVG_W   = SAMPLE_BITS + WEIGHT_BITS;
  localparam int PROD_W  = AVG_W + WEIGHT_BITS + 3;
  localparam int NUM_W   = SAMPLE_BITS + POS_W;
  localparam int WX_W    = (WREG_W > WEIGHT_BITS + 1) ? WREG_W : WEIGHT_BITS + 1;
  localparam int DCMP_W  = (SAMPLE_BITS > DB_W) ? SAMPLE_BITS : DB_W;
  localparam int DIV_CNT_W = $clog2(POS_W + 1);

  // Arithmetic constants
  localparam logic [WX_W-1:0]          WEIGHT_ONE = WX_W'(2 ** WEIGHT_BITS);
  localparam logic signed [PROD_W-1:0] PROD_HALF  = PROD_W'(2 ** (WEIGHT_BITS - 1));
  localparam logic [AVG_W:0]           AVG_HALF   = (AVG_W + 1)'(2 ** (WEIGHT_BITS - 1));
  localparam logic [SAMPLE_BITS-1:0]   SAMPLE_MAX = '1;
  localparam logic [POS_W-1:0]         FULL_SCALE = '1;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = CFG_IDX_W'(1);
  localparam logic [WREG_W-1:0]    WEIGHT_RESET   = WREG_W'(26);
  localparam logic [DB_W-1:0]      DEADBAND_RESET = DB_W'(8);

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_SET_LOW  = 2'd1,
    CMD_SET_HIGH = 2'd2,
    CMD_SET_INV  = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DISP,
    S_MUL,
    S_AVG,
    S_CMP,
    S_NORM,
    S_DIV,
    S_WRITE,
    S_OUT
  } state_t;

  // Per-channel state word held in the channel RAM
  typedef struct packed {
    logic [AVG_W-1:0]       avg;
    logic                   seeded;
    logic [SAMPLE_BITS-1:0] cur;
    logic [SAMPLE_BITS-1:0] rep;
    logic [POS_W-1:0]       scaled;
    logic [SAMPLE_BITS-1:0] cal_lo;
    logic [SAMPLE_BITS-1:0] cal_hi;
    logic                   inv;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  localparam ent_t ENT_RESET = '{
    avg:    '0,
    seeded: 1'b0,
    cur:    '0,
    rep:    '0,
    scaled: '0,
    cal_lo: '0,
    cal_hi: SAMPLE_MAX,
    inv:    1'b0
  };

  // Divider request and response
  typedef struct packed {
    logic                   start;
    logic [NUM_W-1:0]       num;
    logic [SAMPLE_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: src/emadb_if.sv
// Valid/ready channel interfaces of the normaliser: input items, results, config writes.
// Depends on emadb_pkg for the field widths.
`default_nettype none

interface emadb_in_if import emadb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAN_W-1:0] channel;
  logic [VAL_W-1:0]  value;

  modport source (output valid, command, channel, value, input ready);
  modport sink   (input valid, command, channel, value, output ready);
endinterface

interface emadb_out_if import emadb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   out_channel;
  logic [SMOOTH_W-1:0] smoothed;
  logic [POS_W-1:0]    normalized;
  logic                changed;

  modport source (output valid, out_channel, smoothed, normalized, changed, input ready);
  modport sink   (input valid, out_channel, smoothed, normalized, changed, output ready);
endinterface

interface emadb_cfg_if import emadb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/emadb_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module emadb_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/emadb_div.sv
// Restoring divider, one quotient bit per cycle, for the calibrated position.
// Depends on emadb_pkg (div_req_t, div_rsp_t, widths).
`default_nettype none

module emadb_div import emadb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [SAMPLE_BITS-1:0] rem_r;
  logic [SAMPLE_BITS-1:0] den_r;
  logic [POS_W-1:0]       low_r;
  logic [POS_W-1:0]       quo_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   done_r;

  // One trial subtraction; the quotient is known to fit in POS_W bits, so the
  // partial remainder starts from the numerator's upper bits
  logic [SAMPLE_BITS:0] sh;
  logic [SAMPLE_BITS:0] sub;
  logic                 fits;

  always_comb begin
    sh   = {rem_r, low_r[POS_W-1]};
    sub  = sh - {1'b0, den_r};
    fits = (sh >= {1'b0, den_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= DIV_CNT_W'(POS_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == DIV_CNT_W'(1));
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[NUM_W-1:POS_W];
      low_r <= req.num[POS_W-1:0];
      den_r <= req.den;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? sub[SAMPLE_BITS-1:0] : sh[SAMPLE_BITS-1:0];
      low_r <= {low_r[POS_W-2:0], 1'b0};
      quo_r <= {quo_r[POS_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

FILE: src/multichannel_ema_deadband_normalizer.sv
// Top level of the multichannel EMA deadband normaliser: sequencer, channel RAM, divider.
// Depends on emadb_pkg, emadb_if, emadb_ram and emadb_div.
//
// One item is processed at a time. Each item reads its channel's state word from a
// single-port RAM, updates it in a short sequence of steps and writes it back before
// the result is offered, so items on the same channel never overlap. After the RAM read
// and dispatch, a calibration bound write goes straight to write-back; a sample that
// stays within the deadband first passes the multiply, average and compare steps. A
// seeding sample or an invert write goes to the normalisation step, and a reporting
// sample does so after the compare; there the position is set directly when it clamps
// or the calibration is degenerate, and otherwise waits for the 16-step divider, which
// sets the worst case. The input is ready again in the cycle after the result is loaded.
// The result sits in an output register, so the next item is taken while a result
// waits; a second finished result holds the sequencer until the first is taken.
// No clearing pass is needed after reset: a valid bit per channel makes unwritten
// entries read as their reset state. Configuration writes are always accepted.
`default_nettype none

module multichannel_ema_deadband_normalizer import emadb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  emadb_in_if.sink     in_ch,
  emadb_out_if.source  out_ch,
  emadb_cfg_if.sink    cfg_ch
);

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r;
  logic [CHAN_W-1:0]      chan_r;
  logic [SAMPLE_BITS-1:0] val_r;
  logic [SAMPLE_BITS-1:0] norm_v_r;
  ent_t                   ent_r;
  logic                   chg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [WREG_W-1:0]      wt_r;
  logic [DB_W-1:0]        db_r;
  logic [CHANNELS-1:0]    vld_r;

  logic                   out_valid_r;
  logic [CHAN_W-1:0]      out_chan_r;
  logic [SMOOTH_W-1:0]    out_smooth_r;
  logic [POS_W-1:0]       out_pos_r;
  logic                   out_chg_r;

  logic                   in_acc;
  logic                   ram_en, ram_we;
  logic [CH_AW-1:0]       ram_addr;
  logic [ENT_W-1:0]       ram_rdata;
  logic                   out_load;
  logic                   in_range;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r <= WEIGHT_RESET;
      db_r <= DEADBAND_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_WEIGHT) begin
        wt_r <= cfg_ch.data[WREG_W-1:0];
      end else if (cfg_ch.index == REG_DEADBAND) begin
        db_r <= cfg_ch.data[DB_W-1:0];
      end
    end
  end

  // Smoothing arithmetic
  logic [WX_W-1:0]            wt_ext;
  logic [WEIGHT_BITS:0]       w_eff;
  logic signed [AVG_W:0]      delta;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [PROD_W-1:0]   step;
  logic [AVG_W+1:0]           avg_sum;
  logic [AVG_W-1:0]           avg_new;
  logic [AVG_W:0]             cur_sum;
  logic [SAMPLE_BITS:0]       cur_wide;
  logic [SAMPLE_BITS-1:0]     cur_new;
  logic [SAMPLE_BITS-1:0]     diff;
  logic                       report;

  always_comb begin
    // weight above one acts as one
    wt_ext   = WX_W'(wt_r);
    w_eff    = (WEIGHT_BITS + 1)'((wt_ext > WEIGHT_ONE) ? WEIGHT_ONE : wt_ext);
    // avg' = avg + round(w * (raw*F - avg) / F)
    delta    = $signed({1'b0, val_r, {WEIGHT_BITS{1'b0}}}) - $signed({1'b0, ent_r.avg});
    prod_nxt = $signed({1'b0, w_eff}) * $signed(PROD_W'(delta));
    prod_rnd = prod_r + PROD_HALF;
    step     = prod_rnd >>> WEIGHT_BITS;
    avg_sum  = {2'b00, ent_r.avg} + step[AVG_W+1:0];
    avg_new  = avg_sum[AVG_W-1:0];
    // rounded and saturated value
    cur_sum  = {1'b0, ent_r.avg} + AVG_HALF;
    cur_wide = cur_sum[AVG_W:WEIGHT_BITS];
    cur_new  = cur_wide[SAMPLE_BITS] ? SAMPLE_MAX : cur_wide[SAMPLE_BITS-1:0];
    diff     = (cur_new >= ent_r.rep) ? cur_new - ent_r.rep : ent_r.rep - cur_new;
    report   = (DCMP_W'(diff) >= DCMP_W'(db_r));
  end

  // Normalisation set-up
  logic                   degen, below, above, trivial;
  logic [SAMPLE_BITS-1:0] span, offs;
  logic [NUM_W-1:0]       num;
  logic [POS_W-1:0]       triv_pos;

  always_comb begin
    degen = (ent_r.cal_hi <= ent_r.cal_lo);
    below = (norm_v_r <= ent_r.cal_lo);
    above = (norm_v_r >= ent_r.cal_hi);
    trivial = degen || below || above;
    span  = ent_r.cal_hi - ent_r.cal_lo;
    offs  = norm_v_r - ent_r.cal_lo;
    // offs * 65535 + span / 2
    num   = {offs, {POS_W{1'b0}}} - NUM_W'(offs) + NUM_W'(span >> 1);
    if (degen) begin
      triv_pos = '0;
    end else if (below) begin
      triv_pos = ent_r.inv ? FULL_SCALE : '0;
    end else begin
      triv_pos = ent_r.inv ? '0 : FULL_SCALE;
    end
  end

  assign in_range = (int'(chan_r) < CHANNELS);

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_nxt     = state_r;
    in_ch.ready   = 1'b0;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = CH_AW'(chan_r);
    div_req.start = 1'b0;
    div_req.num   = num;
    div_req.den   = span;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        ram_addr    = CH_AW'(in_ch.channel);
        if (in_ch.valid) begin
          ram_en    = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_DISP;
      S_DISP: begin
        if (!in_range) begin
          state_nxt = S_OUT;
        end else begin
          unique case (cmd_r)
            CMD_SAMPLE:   state_nxt = ent_r.seeded ? S_MUL : S_NORM;
            CMD_SET_LOW:  state_nxt = S_WRITE;
            CMD_SET_HIGH: state_nxt = S_WRITE;
            CMD_SET_INV:  state_nxt = S_NORM;
            default:      state_nxt = S_WRITE;
          endcase
        end
      end
      S_MUL: state_nxt = S_AVG;
      S_AVG: state_nxt = S_CMP;
      S_CMP: state_nxt = report ? S_NORM : S_WRITE;
      S_NORM: begin
        if (trivial) begin
          state_nxt = S_WRITE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_acc = in_ch.valid && in_ch.ready;

  // Working copy of the channel entry
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_r  <= cmd_t'(in_ch.command);
          chan_r <= in_ch.channel;
          val_r  <= SAMPLE_BITS'(in_ch.value);
        end
      end
      S_READ: begin
        // an entry never written reads as its reset state
        ent_r <= vld_r[ram_addr] ? ent_t'(ram_rdata) : ENT_RESET;
        chg_r <= 1'b0;
      end
      S_DISP: begin
        unique case (cmd_r)
          CMD_SAMPLE: begin
            if (!ent_r.seeded) begin
              ent_r.seeded <= 1'b1;
              ent_r.avg    <= {val_r, {WEIGHT_BITS{1'b0}}};
              ent_r.cur    <= val_r;
              ent_r.rep    <= val_r;
              norm_v_r     <= val_r;
              chg_r        <= 1'b1;
            end
          end
          CMD_SET_LOW:  ent_r.cal_lo <= val_r;
          CMD_SET_HIGH: ent_r.cal_hi <= val_r;
          CMD_SET_INV: begin
            ent_r.inv <= val_r[0];
            norm_v_r  <= ent_r.cur;
          end
          default: ;
        endcase
      end
      S_MUL: prod_r <= prod_nxt;
      S_AVG: ent_r.avg <= avg_new;
      S_CMP: begin
        ent_r.cur <= cur_new;
        if (report) begin
          ent_r.rep <= cur_new;
          norm_v_r  <= cur_new;
          chg_r     <= 1'b1;
        end
      end
      S_NORM: begin
        if (trivial) begin
          ent_r.scaled <= triv_pos;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          ent_r.scaled <= ent_r.inv ? ~div_rsp.quo : div_rsp.quo;
        end
      end
      default: ;
    endcase
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_addr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r   <= chan_r;
      out_smooth_r <= in_range ? SMOOTH_W'(ent_r.cur) : '0;
      out_pos_r    <= in_range ? ent_r.scaled : '0;
      out_chg_r    <= in_range && chg_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_channel = out_chan_r;
  assign out_ch.smoothed    = out_smooth_r;
  assign out_ch.normalized  = out_pos_r;
  assign out_ch.changed     = out_chg_r;

  // Channel state memory
  emadb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ent_r),
    .rdata (ram_rdata)
  );

  // Position divider
  emadb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // An accepted item always starts with the RAM read
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_READ))
    else $error("accepted item did not move to the RAM read");

  // A loaded result is offered in the next cycle
  a_load_offers: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_ch.valid && (state_r == S_IDLE)))
    else $error("loaded result not offered");

  // Divider completion leads straight to write-back
  a_div_writes: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && div_rsp.done) |=> (state_r == S_WRITE))
    else $error("divider result not written back");

  // Only a sample can flag a change
  a_chg_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (cmd_r != CMD_SAMPLE)) |-> !chg_r)
    else $error("change flagged for a command item");

  // A written entry is marked valid
  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> vld_r[$past(ram_addr)])
    else $error("written entry not marked valid");

endmodule

`default_nettype wire

FILE: verif/tb_multichannel_ema_deadband_normalizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multichannel EMA deadband normaliser.
// Depends on emadb_pkg, the emadb channel interfaces and the block's RTL.

module tb_multichannel_ema_deadband_normalizer;
  import emadb_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 158;
  localparam int HOLD_CYCLES   = 300;

  // Register indexes the block does not implement
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [SMOOTH_W-1:0] smoothed;
    logic [POS_W-1:0]    normalized;
    logic                changed;
  } ema_result_t;

  // Per-channel smoothing model and queue of expected results
  class ema_scoreboard;
    logic [WREG_W-1:0]      weight;
    logic [DB_W-1:0]        band;
    logic [AVG_W-1:0]       avg_mem  [CHANNELS];
    bit                     seed_mem [CHANNELS];
    logic [SAMPLE_BITS-1:0] cur_mem  [CHANNELS];
    logic [SAMPLE_BITS-1:0] rep_mem  [CHANNELS];
    logic [POS_W-1:0]       pos_mem  [CHANNELS];
    logic [SAMPLE_BITS-1:0] lo_mem   [CHANNELS];
    logic [SAMPLE_BITS-1:0] hi_mem   [CHANNELS];
    bit                     inv_mem  [CHANNELS];
    ema_result_t            expected_q [$];
    int                     errors;

    function new();
      weight = WEIGHT_RESET;
      band   = DEADBAND_RESET;
      errors = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        avg_mem[i]  = '0;
        seed_mem[i] = 1'b0;
        cur_mem[i]  = '0;
        rep_mem[i]  = '0;
        pos_mem[i]  = '0;
        lo_mem[i]   = '0;
        hi_mem[i]   = '1;
        inv_mem[i]  = 1'b0;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_WEIGHT)
        weight = data[WREG_W-1:0];
      else if (idx == REG_DEADBAND)
        band = data[DB_W-1:0];
    endfunction

    // Calibrated Q0.16 position of a value on one channel
    function logic [POS_W-1:0] scale_position(int ch, logic [SAMPLE_BITS-1:0] v);
      longint lo, hi, x, span, p;
      lo = longint'(lo_mem[ch]);
      hi = longint'(hi_mem[ch]);
      x  = longint'(v);
      if (hi <= lo) return '0;
      if (x <= lo) p = 0;
      else if (x >= hi) p = 65535;
      else begin
        span = hi - lo;
        p = ((x - lo) * 65535 + span / 2) / span;
        if (p > 65535) p = 65535;
      end
      if (inv_mem[ch]) p = 65535 - p;
      return POS_W'(p);
    endfunction

    // Works out the result of an accepted item and queues it
    function void note_item(cmd_t cmd, int ch, logic [VAL_W-1:0] val);
      ema_result_t r;
      longint w, acc, c, d;
      r.changed = 1'b0;
      case (cmd)
        CMD_SAMPLE: begin
          if (!seed_mem[ch]) begin
            seed_mem[ch] = 1'b1;
            avg_mem[ch]  = AVG_W'(longint'(val) << WEIGHT_BITS);
            cur_mem[ch]  = val;
            rep_mem[ch]  = val;
            pos_mem[ch]  = scale_position(ch, val);
            r.changed    = 1'b1;
          end else begin
            w = longint'(weight);
            if (w > (1 << WEIGHT_BITS)) w = 1 << WEIGHT_BITS;
            acc = w * (longint'(val) << WEIGHT_BITS)
                + ((1 << WEIGHT_BITS) - w) * longint'(avg_mem[ch])
                + (1 << (WEIGHT_BITS - 1));
            avg_mem[ch] = AVG_W'(acc >> WEIGHT_BITS);
            c = (longint'(avg_mem[ch]) + (1 << (WEIGHT_BITS - 1))) >> WEIGHT_BITS;
            if (c > longint'(SAMPLE_MAX)) c = longint'(SAMPLE_MAX);
            cur_mem[ch] = SAMPLE_BITS'(c);
            d = c - longint'(rep_mem[ch]);
            if (d < 0) d = -d;
            if (d >= longint'(band)) begin
              rep_mem[ch] = cur_mem[ch];
              pos_mem[ch] = scale_position(ch, cur_mem[ch]);
              r.changed   = 1'b1;
            end
          end
        end
        CMD_SET_LOW:  lo_mem[ch] = val;
        CMD_SET_HIGH: hi_mem[ch] = val;
        default: begin
          inv_mem[ch] = val[0];
          pos_mem[ch] = scale_position(ch, cur_mem[ch]);
        end
      endcase
      r.chan       = CHAN_W'(ch);
      r.smoothed   = cur_mem[ch];
      r.normalized = pos_mem[ch];
      expected_q.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(ema_result_t got);
      ema_result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("result on channel %0d with nothing expected", got.chan));
        return;
      end
      exp = expected_q.pop_front();
      if (got.chan !== exp.chan)
        report($sformatf("out_channel %0d, expected %0d", got.chan, exp.chan));
      if (got.smoothed !== exp.smoothed)
        report($sformatf("ch %0d smoothed %0d, expected %0d",
                         exp.chan, got.smoothed, exp.smoothed));
      if (got.normalized !== exp.normalized)
        report($sformatf("ch %0d normalized %0d, expected %0d",
                         exp.chan, got.normalized, exp.normalized));
      if (got.changed !== exp.changed)
        report($sformatf("ch %0d changed %0b, expected %0b",
                         exp.chan, got.changed, exp.changed));
    endtask
  endclass

  logic clk;
  logic rst_n;

  emadb_in_if  in_if ();
  emadb_out_if out_if ();
  emadb_cfg_if cfg_if ();

  multichannel_ema_deadband_normalizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  ema_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int walk_level [CHANNELS];

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: check accepted items, then pick the next ready level
  initial begin
    ema_result_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.chan       = out_if.out_channel;
        got.smoothed   = out_if.smoothed;
        got.normalized = out_if.normalized;
        got.changed    = out_if.changed;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(cmd_t cmd, int ch, int val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.channel <= CHAN_W'(ch);
    in_if.value   <= VAL_W'(val);
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(cmd, ch, VAL_W'(val));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Weight goes in the low bits; the unused upper data bits are randomised
  task automatic set_config(int weight, int band);
    write_reg(REG_WEIGHT, {3'($urandom_range(0, 7)), WREG_W'(weight)});
    write_reg(REG_DEADBAND, DB_W'(band));
  endtask

  // Stop offering items and wait for every outstanding result
  task automatic drain(bit settle);
    in_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly slider-like traffic: random walks per channel, sane calibration,
  // invert toggles, plus a slice of unconstrained noise
  task automatic send_random();
    int r, ch, step, sel, v;
    r  = $urandom_range(0, 99);
    ch = $urandom_range(0, CHANNELS - 1);
    if (r < 8) begin
      send_item(cmd_t'($urandom_range(0, 3)), ch, $urandom_range(0, 4095));
    end else if (r < 72) begin
      sel = $urandom_range(0, 9);
      step = (sel < 5) ? 3 : (sel < 8) ? 40 : 600;
      v = walk_level[ch] + $urandom_range(0, 2 * step) - step;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      walk_level[ch] = v;
      send_item(CMD_SAMPLE, ch, v);
    end else if (r < 82) begin
      send_item(CMD_SET_LOW, ch, $urandom_range(0, 1800));
    end else if (r < 92) begin
      send_item(CMD_SET_HIGH, ch, $urandom_range(2200, 4095));
    end else begin
      send_item(CMD_SET_INV, ch, $urandom_range(0, 4095));
    end
  endtask

  task automatic run_phase(int count, int pause_at, int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain(1'b0);
      if (i == hold_at) hold_left = HOLD_CYCLES;
      send_random();
    end
    drain(1'b1);
  endtask

  // Main sequence
  initial begin
    for (int i = 0; i < CHANNELS; i++) walk_level[i] = 2048;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.command <= CMD_SAMPLE;
    in_if.channel <= '0;
    in_if.value   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= REG_WEIGHT;
    cfg_if.data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: seeding, deadband, calibration, inversion at reset settings
    send_item(CMD_SAMPLE,   0, 0);
    send_item(CMD_SAMPLE,   1, 4095);
    send_item(CMD_SAMPLE,   0, 4095);
    send_item(CMD_SAMPLE,   1, 4090);
    send_item(CMD_SET_LOW,  2, 1000);
    send_item(CMD_SET_HIGH, 2, 3000);
    send_item(CMD_SAMPLE,   2, 2000);
    send_item(CMD_SET_INV,  2, 1);
    // degenerate calibration, equal and inverted bounds
    send_item(CMD_SET_LOW,  2, 3000);
    send_item(CMD_SET_INV,  2, 1);
    send_item(CMD_SET_HIGH, 2, 0);
    send_item(CMD_SET_INV,  2, 12'hFFE);
    // invert on an unseeded channel, then seed into a degenerate range
    send_item(CMD_SET_INV,  3, 1);
    send_item(CMD_SET_LOW,  3, 4095);
    send_item(CMD_SAMPLE,   3, 2048);
    send_item(CMD_SAMPLE,   7, 1);
    send_item(CMD_SAMPLE,   7, 4094);
    drain(1'b1);

    // Oversized weight acts as full weight; zero deadband reports every sample
    set_config(300, 0);
    send_item(CMD_SAMPLE, 0, 1234);
    send_item(CMD_SAMPLE, 0, 1234);
    send_item(CMD_SAMPLE, 6, 7);
    drain(1'b1);

    // Zero weight freezes the average
    set_config(0, 1);
    send_item(CMD_SAMPLE,  0, 4095);
    send_item(CMD_SAMPLE,  1, 0);
    send_item(CMD_SET_INV, 1, 1);
    drain(1'b1);

    // Sender sparse-ish, receiver mostly stalled
    send_idle_pct = 36;
    recv_idle_pct = 68;
    set_config(256, 0);
    run_phase(PHASE_ITEMS, -1, -1);
    set_config(1, 4095);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 4095)));
    run_phase(PHASE_ITEMS, 80, -1);

    // Roles swapped
    send_idle_pct = 68;
    recv_idle_pct = 36;
    set_config(0, 1);
    run_phase(PHASE_ITEMS, -1, -1);
    set_config(511, 16);
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 4095)));
    run_phase(PHASE_ITEMS, -1, -1);

    // Back to back, with one long result-side hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config($urandom_range(1, 256), $urandom_range(0, 64));
    run_phase(PHASE_ITEMS, -1, 30);
    set_config($urandom_range(2, 255), 3);
    run_phase(PHASE_ITEMS, -1, -1);

    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: multichannel_ema_deadband_normalizer.f
src/emadb_pkg.sv
src/emadb_if.sv
src/emadb_ram.sv
src/emadb_div.sv
src/multichannel_ema_deadband_normalizer.sv
verif/tb_multichannel_ema_deadband_normalizer.sv
